FILE: src/nubx_pkg.sv
// Shared types and constants for the NMEA/UBX frame receiver.
`default_nettype none
package nubx_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_NMEA    = 3'd1,
    PH_SYNC2   = 3'd2,
    PH_HEADER  = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  // Event code reported with every byte
  typedef enum logic [2:0] {
    EV_IGNORED  = 3'd0,
    EV_NMEA     = 3'd1,
    EV_NMEA_END = 3'd2,
    EV_UBX      = 3'd3,
    EV_UBX_END  = 3'd4,
    EV_OVERFLOW = 3'd5
  } event_t;

  localparam logic [7:0]  NMEA_START  = 8'h24;
  localparam logic [7:0]  NMEA_STOP   = 8'h2A;
  localparam logic [7:0]  SYNC1       = 8'hB5;
  localparam logic [7:0]  SYNC2       = 8'h62;
  localparam logic [7:0]  ACK_CLASS   = 8'h05;
  localparam logic [7:0]  ACK_ID      = 8'h01;
  localparam logic [16:0] HEADER_LEN  = 17'd6;
  localparam logic [16:0] OVERHEAD    = 17'd8;
  localparam logic [15:0] POS_CLASS   = 16'd2;
  localparam logic [15:0] POS_ID      = 16'd3;
  localparam logic [15:0] POS_LEN_LO  = 16'd4;
  localparam logic [15:0] MAX_FRAME_RESET = 16'd120;

  // One result item
  typedef struct packed {
    event_t      event_res;
    logic [7:0]  data;
    logic [15:0] position;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic        checksum_ok;
    logic        is_ack;
  } result_t;

endpackage
`default_nettype wire

FILE: src/nubx_in_stage.sv
// Input register stage holding one received byte until the parser takes it.
`default_nettype none
module nubx_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       advance,
  output logic            byte_valid,
  output logic [7:0]      byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // Free slot when empty or when the held byte moves on this cycle
  assign in_tready  = !valid_r || advance;
  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold the valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the byte on each input transfer
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

endmodule
`default_nettype wire

FILE: src/nubx_parser.sv
// Frame parser state, checksum sums and per-byte result logic.
`default_nettype none
module nubx_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wen,
  input  wire logic [15:0]       cfg_wdata,
  input  wire logic              advance,
  input  wire logic [7:0]        rx_byte,
  output nubx_pkg::result_t      result
);
  import nubx_pkg::*;

  logic [15:0] max_frame_r;
  phase_t      phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  rx_sum_a_r, rx_sum_a_nxt;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] count_inc;
  logic [15:0] plen_hdr;
  logic [16:0] frame_need;
  logic [16:0] body_end;
  logic        p_over;

  // Fletcher-8 step and shared compares
  assign add_a      = sum_a_r + rx_byte;
  assign add_b      = sum_b_r + add_a;
  assign count_inc  = count_r + 16'd1;
  assign plen_hdr   = {rx_byte, plen_r[7:0]};
  assign frame_need = {1'b0, plen_hdr} + OVERHEAD;
  assign body_end   = {1'b0, plen_r} + HEADER_LEN;
  assign p_over     = (count_r >= max_frame_r);

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    plen_nxt     = plen_r;
    class_nxt    = class_r;
    id_nxt       = id_r;
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    rx_sum_a_nxt = rx_sum_a_r;
    result             = '0;
    result.event_res   = EV_IGNORED;
    result.data        = rx_byte;

    case (phase_r)
      PH_WAIT: begin
        if (rx_byte == NMEA_START) begin
          phase_nxt = PH_NMEA;
          count_nxt = '0;
        end else if (rx_byte == SYNC1) begin
          if (max_frame_r == '0) begin
            result.event_res = EV_OVERFLOW;
          end else begin
            result.event_res = EV_UBX;
            phase_nxt        = PH_SYNC2;
            count_nxt        = 16'd1;
          end
        end
      end
      PH_NMEA: begin
        result.position = count_r;
        if (rx_byte == NMEA_STOP) begin
          result.event_res = EV_NMEA_END;
          phase_nxt        = PH_WAIT;
          count_nxt        = '0;
        end else if (p_over) begin
          result.event_res = EV_OVERFLOW;
          phase_nxt        = PH_WAIT;
          count_nxt        = '0;
        end else begin
          result.event_res = EV_NMEA;
          count_nxt        = count_inc;
        end
      end
      PH_SYNC2: begin
        if (rx_byte == SYNC2 && !p_over) begin
          result.event_res = EV_UBX;
          result.position  = count_r;
          phase_nxt        = PH_HEADER;
          count_nxt        = count_inc;
          sum_a_nxt        = '0;
          sum_b_nxt        = '0;
        end else if (rx_byte == SYNC2) begin
          result.event_res = EV_OVERFLOW;
          result.position  = count_r;
          phase_nxt        = PH_WAIT;
          count_nxt        = '0;
        end else begin
          // Wrong second sync: drop back to waiting
          phase_nxt = PH_WAIT;
          count_nxt = '0;
        end
      end
      PH_HEADER: begin
        result.position = count_r;
        if (p_over) begin
          result.event_res = EV_OVERFLOW;
          phase_nxt        = PH_WAIT;
          count_nxt        = '0;
        end else begin
          sum_a_nxt        = add_a;
          sum_b_nxt        = add_b;
          result.event_res = EV_UBX;
          count_nxt        = count_inc;
          if (count_r == POS_CLASS) begin
            class_nxt = rx_byte;
          end else if (count_r == POS_ID) begin
            id_nxt = rx_byte;
          end else if (count_r == POS_LEN_LO) begin
            plen_nxt = {8'd0, rx_byte};
          end else begin
            plen_nxt = plen_hdr;
            if (frame_need > {1'b0, max_frame_r}) begin
              result.event_res = EV_OVERFLOW;
              phase_nxt        = PH_WAIT;
              count_nxt        = '0;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
      end
      PH_PAYLOAD: begin
        result.position = count_r;
        if ({1'b0, count_r} < body_end) begin
          sum_a_nxt        = add_a;
          sum_b_nxt        = add_b;
          result.event_res = EV_UBX;
          count_nxt        = count_inc;
        end else if ({1'b0, count_r} == body_end) begin
          rx_sum_a_nxt     = rx_byte;
          result.event_res = EV_UBX;
          count_nxt        = count_inc;
        end else begin
          result.event_res   = EV_UBX_END;
          result.frame_class = class_r;
          result.frame_id    = id_r;
          result.checksum_ok = (rx_sum_a_r == sum_a_r) && (rx_byte == sum_b_r);
          result.is_ack      = (class_r == ACK_CLASS) && (id_r == ACK_ID);
          phase_nxt          = PH_WAIT;
          count_nxt          = '0;
        end
      end
      default: begin
        phase_nxt = PH_WAIT;
        count_nxt = '0;
      end
    endcase
  end

  // Frame length limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= MAX_FRAME_RESET;
    end else if (cfg_wen) begin
      max_frame_r <= cfg_wdata;
    end
  end

  // Commit parser state when a byte moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_WAIT;
      count_r    <= '0;
      plen_r     <= '0;
      class_r    <= '0;
      id_r       <= '0;
      sum_a_r    <= '0;
      sum_b_r    <= '0;
      rx_sum_a_r <= '0;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      plen_r     <= plen_nxt;
      class_r    <= class_nxt;
      id_r       <= id_nxt;
      sum_a_r    <= sum_a_nxt;
      sum_b_r    <= sum_b_nxt;
      rx_sum_a_r <= rx_sum_a_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/nubx_out_reg.sv
// Result register driving the output stream.
`default_nettype none
module nubx_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_valid,
  input  wire nubx_pkg::result_t result,
  output logic                   advance,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [47:0]            out_tdata,
  output logic [2:0]             out_tuser
);
  import nubx_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // Move a byte on when the result slot is free or being drained
  assign advance = byte_valid && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.event_res;
  assign out_tdata  = {6'd0, res_r.is_ack, res_r.checksum_ok, res_r.frame_id,
                       res_r.frame_class, res_r.position, res_r.data};

endmodule
`default_nettype wire

FILE: src/nmea_ubx_frame_receiver.sv
// Top level of the NMEA/UBX frame receiver.
//
//   channel | direction | payload
//   in_     | slave     | tdata[7:0] received byte
//   out_    | master    | tuser event code; tdata byte, position, class, id, flags
//   cfg_    | write     | wdata[15:0] longest accepted frame in bytes
//
// Each byte passes through the input register and then the result register
// between input transfer and result. A byte can be taken every cycle while the
// output is not stalled. The parser state updates in one pass when a byte moves
// to the result register. Reset clears the parser and sets the frame limit to 120.
// A stalled output holds the result and one more byte in the input register.
`default_nettype none
module nmea_ubx_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [7:0] data, [23:8] position, [31:24] frame_class,
                                       // [39:32] frame_id, [40] checksum_ok, [41] is_ack
  output logic [2:0]       out_tuser,  // [2:0] event_res
  input  wire logic        cfg_wen,
  input  wire logic [15:0] cfg_wdata   // [15:0] max_frame_bytes
);
  import nubx_pkg::*;

  logic       advance;
  logic       byte_valid;
  logic [7:0] byte_data;
  result_t    result;

  nubx_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  nubx_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .rx_byte   (byte_data),
    .result    (result)
  );

  nubx_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .result     (result),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
